FILE: hw/rtl/fp4_block_scaled_dequant_bf16_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the FP4 block-scaled dequantiser
// Clocked assertion helpers shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef FP4_BLOCK_SCALED_DEQUANT_BF16_MACROS_SVH
`define FP4_BLOCK_SCALED_DEQUANT_BF16_MACROS_SVH

// Property checked on every rising edge, suspended while reset is high.
`define FP4DQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define FP4DQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/fp4dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp4dq_pkg
// Types, constants and helper functions of the FP4 dequantiser.
// ----------------------------------------------------------------------------
package fp4dq_pkg;

   localparam logic [31:0] GLOBAL_SCALE_RESET = 32'h3F80_0000;
   localparam logic [31:0] FP32_DEFAULT_NAN   = 32'hFFC0_0000;
   localparam logic [31:0] FP32_QUIET_BIT     = 32'h0040_0000;
   localparam logic [15:0] BF16_QUIET_BIT     = 16'h0040;
   localparam logic [31:0] BF16_ROUND_HALF    = 32'h0000_8000;
   localparam logic [7:0]  FP32_EXP_MAX       = 8'hFF;
   localparam logic signed [9:0] FP32_BIAS    = 10'sd127;

   // unpacked operand: biased exponent (may go below 1) and normalised mantissa
   typedef struct packed {
      logic signed [9:0] e;
      logic [23:0]       m;
   } fp4dq_unp_type;

   function automatic logic [4:0] lzc24(input logic [23:0] x);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (x[i]) n = 5'(23 - i);
      end
      return n;
   endfunction

   function automatic fp4dq_unp_type unpack(input logic [31:0] x);
      fp4dq_unp_type u;
      logic [4:0]    lz;
      lz = lzc24({1'b0, x[22:0]});
      if (x[30:23] != 8'd0) begin
         u.e = signed'({2'b00, x[30:23]});
         u.m = {1'b1, x[22:0]};
      end else begin
         u.e = 10'sd1 - signed'({5'b00000, lz});
         u.m = {1'b0, x[22:0]} << lz;
      end
      return u;
   endfunction

   // exact E4M3 value as fp32 bits; all-ones magnitude lands on 480 naturally
   function automatic logic [31:0] decode_e4m3(input logic [7:0] c);
      logic [31:0] mag;
      if (c[6:3] != 4'd0) begin
         mag = {1'b0, 8'(c[6:3] + 8'd120), c[2:0], 20'd0};
      end else begin
         case (c[2:0])
            3'd0:    mag = 32'd0;
            3'd1:    mag = {1'b0, 8'd118, 23'd0};
            3'd2:    mag = {1'b0, 8'd119, 23'd0};
            3'd3:    mag = {1'b0, 8'd119, 23'h40_0000};
            default: mag = {1'b0, 8'd120, c[1:0], 21'd0};
         endcase
      end
      return {c[7], mag[30:0]};
   endfunction

   function automatic logic [31:0] decode_e2m1(input logic [3:0] c);
      logic [31:0] mag;
      if (c[2:1] != 2'd0) begin
         mag = {1'b0, 8'(c[2:1] + 8'd126), c[0], 22'd0};
      end else begin
         mag = c[0] ? 32'h3F00_0000 : 32'd0;
      end
      return {c[3], mag[30:0]};
   endfunction

   // fp32 to bf16, ties away from zero, NaN made quiet
   function automatic logic [15:0] to_bf16(input logic [31:0] u);
      logic [31:0] r;
      r = u + BF16_ROUND_HALF;
      if (u[30:23] == FP32_EXP_MAX && u[22:0] != 23'd0) begin
         return u[31:16] | BF16_QUIET_BIT;
      end
      return r[31:16];
   endfunction

endpackage

FILE: hw/rtl/fp4dq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp4dq channel interfaces
// Valid/ready channels for requests, responses and the scale register.
// ----------------------------------------------------------------------------
interface fp4dq_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   logic [7:0] high_scale_code;
   logic [7:0] low_scale_code;
   modport source (output valid, packed_byte, high_scale_code, low_scale_code, input ready);
   modport sink   (input valid, packed_byte, high_scale_code, low_scale_code, output ready);
endinterface

interface fp4dq_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] high_value;
   logic [15:0] low_value;
   modport source (output valid, high_value, low_value, input ready);
   modport sink   (input valid, high_value, low_value, output ready);
endinterface

interface fp4dq_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/fp4_block_scaled_dequant_bf16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp4_block_scaled_dequant_bf16
// Dequantises two E2M1 elements per transfer into two bf16 words.
// ----------------------------------------------------------------------------
// Use:
//  - req carries one packed byte (high nibble first) and an E4M3 block scale
//    for each nibble; rsp returns high_value and low_value as bf16 bits.
//  - csr writes the fp32 global scale; always ready. Write it only while
//    the pipeline is empty. Reset value is 1.0.
//  - Each element: bf16(q * fp32(s * g)); fp32 rounding is nearest even,
//    bf16 rounding is ties away from zero, NaNs come out quiet.
// Timing:
//  - From req transfer to rsp valid, each lane passes through two four-stage
//    fp32 multipliers in series, then the bf16 output register.
//  - Throughput one transfer per cycle while rsp is not stalled; the
//    multiplier stages take a new operand pair on every enabled cycle.
// Reset and stall:
//  - Synchronous reset clears the valid bits and restores the global scale.
//  - A stalled rsp freezes the whole pipeline; req.ready drops only while a
//    result is held and not taken, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "fp4_block_scaled_dequant_bf16_macros.svh"

module fp4_block_scaled_dequant_bf16
   import fp4dq_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   fp4dq_req_if.sink   req,
   fp4dq_rsp_if.source rsp,
   fp4dq_csr_if.sink   csr
);

   localparam int MulStages = 4;
   localparam int Stages    = 2 * MulStages;

   logic [31:0] global_scale_ff;

   // one enable for every stage: advance unless the output is held
   logic en;
   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         global_scale_ff <= GLOBAL_SCALE_RESET;
      end else if (csr.valid) begin
         global_scale_ff <= csr.data;
      end
   end

   // valid bits travel beside the data
   logic [Stages-1:0] vld_ff, vld_in;
   logic              out_vld_ff;
   assign vld_in = {vld_ff[Stages-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[Stages-1];
      end
   end

   // first product: block scale times global scale
   logic [31:0] hs_prod, ls_prod, hi_prod, lo_prod;

   fp4dq_fmul u_hi_scale (
      .clock (clock), .en (en),
      .a (decode_e4m3(req.high_scale_code)), .b (global_scale_ff), .y (hs_prod)
   );
   fp4dq_fmul u_lo_scale (
      .clock (clock), .en (en),
      .a (decode_e4m3(req.low_scale_code)), .b (global_scale_ff), .y (ls_prod)
   );

   // element values wait alongside the first multiplier
   logic [31:0] qh_ff [MulStages];
   logic [31:0] ql_ff [MulStages];

   always_ff @(posedge clock) begin
      if (en) begin
         qh_ff[0] <= decode_e2m1(req.packed_byte[7:4]);
         ql_ff[0] <= decode_e2m1(req.packed_byte[3:0]);
         for (int i = 1; i < MulStages; i++) begin
            qh_ff[i] <= qh_ff[i-1];
            ql_ff[i] <= ql_ff[i-1];
         end
      end
   end

   // second product: element times combined scale
   fp4dq_fmul u_hi_elem (
      .clock (clock), .en (en),
      .a (qh_ff[MulStages-1]), .b (hs_prod), .y (hi_prod)
   );
   fp4dq_fmul u_lo_elem (
      .clock (clock), .en (en),
      .a (ql_ff[MulStages-1]), .b (ls_prod), .y (lo_prod)
   );

   // bf16 output register
   logic [15:0] hi_ff, lo_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff <= to_bf16(hi_prod);
         lo_ff <= to_bf16(lo_prod);
      end
   end

   assign rsp.valid      = out_vld_ff;
   assign rsp.high_value = hi_ff;
   assign rsp.low_value  = lo_ff;

   // last stage full and pipeline advancing means a result next cycle
   `FP4DQ_ASSERT(a_last_to_out, clock, reset, (en && vld_ff[Stages-1]) |=> rsp.valid, "result lost at output stage")
   // NaN results always carry the quiet bit
   `FP4DQ_ASSERT(a_hi_quiet, clock, reset, (rsp.valid && rsp.high_value[14:7] == 8'hFF && rsp.high_value[6:0] != 7'd0) |-> rsp.high_value[6], "high NaN not quiet")
   `FP4DQ_ASSERT(a_lo_quiet, clock, reset, (rsp.valid && rsp.low_value[14:7] == 8'hFF && rsp.low_value[6:0] != 7'd0) |-> rsp.low_value[6], "low NaN not quiet")

endmodule

FILE: hw/rtl/fp4dq_fmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp4dq_fmul
// Four-stage fp32 multiplier, round to nearest even, gradual underflow.
// ----------------------------------------------------------------------------
module fp4dq_fmul
   import fp4dq_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);

   // stage A: unpack, special cases
   logic              sa_s_ff, sa_spec_ff;
   logic [31:0]       sa_sw_ff;
   fp4dq_unp_type     sa_a_ff, sa_b_ff;
   logic              sa_s_in, sa_spec_in;
   logic [31:0]       sa_sw_in;
   logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

   assign a_nan  = (a[30:23] == FP32_EXP_MAX) && (a[22:0] != 23'd0);
   assign b_nan  = (b[30:23] == FP32_EXP_MAX) && (b[22:0] != 23'd0);
   assign a_inf  = (a[30:23] == FP32_EXP_MAX) && (a[22:0] == 23'd0);
   assign b_inf  = (b[30:23] == FP32_EXP_MAX) && (b[22:0] == 23'd0);
   assign a_zero = (a[30:0] == 31'd0);
   assign b_zero = (b[30:0] == 31'd0);
   assign sa_s_in = a[31] ^ b[31];

   always_comb begin
      sa_spec_in = 1'b1;
      if (a_nan)                                     sa_sw_in = a | FP32_QUIET_BIT;
      else if (b_nan)                                sa_sw_in = b | FP32_QUIET_BIT;
      else if ((a_inf && b_zero) || (a_zero && b_inf)) sa_sw_in = FP32_DEFAULT_NAN;
      else if (a_inf || b_inf)                       sa_sw_in = {sa_s_in, FP32_EXP_MAX, 23'd0};
      else if (a_zero || b_zero)                     sa_sw_in = {sa_s_in, 31'd0};
      else begin
         sa_sw_in   = 32'd0;
         sa_spec_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_s_ff    <= sa_s_in;
         sa_spec_ff <= sa_spec_in;
         sa_sw_ff   <= sa_sw_in;
         sa_a_ff    <= unpack(a);
         sa_b_ff    <= unpack(b);
      end
   end

   // stage B: mantissa product, exponent sum
   logic              sb_s_ff, sb_spec_ff;
   logic [31:0]       sb_sw_ff;
   logic signed [9:0] sb_e_ff;
   logic [47:0]       sb_p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sb_s_ff    <= sa_s_ff;
         sb_spec_ff <= sa_spec_ff;
         sb_sw_ff   <= sa_sw_ff;
         sb_e_ff    <= sa_a_ff.e + sa_b_ff.e - FP32_BIAS;
         sb_p_ff    <= 48'(sa_a_ff.m) * 48'(sa_b_ff.m);
      end
   end

   // stage C: normalise, denormal shift with sticky
   logic              sc_s_ff, sc_spec_ff, sc_ovf_ff, sc_st_ff;
   logic [31:0]       sc_sw_ff;
   logic [7:0]        sc_ef_ff;
   logic [24:0]       sc_t_ff;
   logic [47:0]       norm, shifted;
   logic signed [9:0] e1, sh;
   logic [5:0]        shc;
   logic              lost;

   always_comb begin
      if (sb_p_ff[47]) begin
         norm = sb_p_ff;
         e1   = sb_e_ff + 10'sd1;
      end else begin
         norm = {sb_p_ff[46:0], 1'b0};
         e1   = sb_e_ff;
      end
      sh  = (e1 > 10'sd0) ? 10'sd0 : (10'sd1 - e1);
      shc = (sh > 10'sd48) ? 6'd48 : sh[5:0];
      shifted = norm >> shc;
      lost    = |(norm & ~({48{1'b1}} << shc));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc_s_ff    <= sb_s_ff;
         sc_spec_ff <= sb_spec_ff;
         sc_sw_ff   <= sb_sw_ff;
         sc_ovf_ff  <= (e1 >= 10'sd255);
         sc_ef_ff   <= (e1 > 10'sd0) ? e1[7:0] : 8'd0;
         sc_t_ff    <= shifted[47:23];
         sc_st_ff   <= lost | (|shifted[22:0]);
      end
   end

   // stage D: round and pack; carry out of the mantissa bumps the exponent
   logic [31:0] y_ff;
   logic        rnd;
   logic [30:0] mag;

   assign rnd = sc_t_ff[0] & (sc_st_ff | sc_t_ff[1]);
   assign mag = {sc_ef_ff, sc_t_ff[23:1]} + 31'(rnd);

   always_ff @(posedge clock) begin
      if (en) begin
         if (sc_spec_ff)     y_ff <= sc_sw_ff;
         else if (sc_ovf_ff) y_ff <= {sc_s_ff, FP32_EXP_MAX, 23'd0};
         else                y_ff <= {sc_s_ff, mag};
      end
   end

   assign y = y_ff;

endmodule
